// ===== sv/vector4_normalize_defines.svh =====
// Assertion macros for vector4_normalize, the one file that carries checks.
`ifndef VECTOR4_NORMALIZE_DEFINES_SVH
`define VECTOR4_NORMALIZE_DEFINES_SVH

// Checks a property on the rising clock edge, ignored while reset is high.
`define VN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on the rising clock edge, reset included.
`define VN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/vn_pkg.sv =====
package vn_pkg;

  // Component and result widths.
  localparam int CW = 32;
  localparam int FB = 30;
  localparam int UW = FB + 2;
  localparam int MW = CW;
  localparam int LW = CW + 1;
  localparam int PW = 2 * MW;
  localparam int SW = 2 * LW;
  localparam int QW = FB + 1;
  localparam int LANES = 4;

  // Pipeline depths of the root and divider units.
  localparam int SQ_STEPS = LW;
  localparam int DIV_STEPS = QW;

  // Request data carried alongside the root unit.
  typedef struct packed {
    logic [LANES-1:0]         neg;
    logic [LANES-1:0][MW-1:0] mag;
  } side_t;

  // Request data carried alongside the divider lanes.
  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [LANES-1:0] neg;
    logic [LW-1:0]    len;
  } tail_t;

endpackage

// ===== sv/vn_isqrt.sv =====
module vn_isqrt
  import vn_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_in,
  input  logic [SW-1:0] sum_in,
  input  side_t         side_in,
  output logic          valid_out,
  output logic [LW-1:0] root_out,
  output side_t         side_out
);

  logic [SW-1:0] rem  [0:SQ_STEPS];
  logic [LW-1:0] res  [0:SQ_STEPS];
  side_t         side [0:SQ_STEPS];
  logic [SQ_STEPS:0] vld;

  assign rem[0]  = sum_in;
  assign res[0]  = '0;
  assign side[0] = side_in;
  assign vld[0]  = valid_in;

  // One result bit per stage, most significant first.
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam int B = SQ_STEPS - 1 - k;
    logic [SW-1:0] trial;
    logic          take;

    // Trial term 2*res*2^B + 2^(2B); the low bits of res are still clear.
    assign trial = (SW'(res[k]) << (B + 1)) | (SW'(1) << (2 * B));
    assign take  = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? rem[k] - trial : rem[k];
        res[k+1]  <= take ? res[k] | (LW'(1) << B) : res[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign valid_out = vld[SQ_STEPS];
  assign root_out  = res[SQ_STEPS];
  assign side_out  = side[SQ_STEPS];

endmodule

// ===== sv/vn_div_lane.sv =====
module vn_div_lane
  import vn_pkg::*;
(
  input  logic          clk,
  input  logic          en,
  input  logic [MW-1:0] mag_in,
  input  logic [LW-1:0] len_in,
  output logic [QW-1:0] quot_out
);

  logic [LW-1:0] rem  [0:DIV_STEPS];
  logic [LW-1:0] dvs  [0:DIV_STEPS];
  logic [QW-1:0] quot [0:DIV_STEPS];

  assign rem[0]  = LW'(mag_in);
  assign dvs[0]  = len_in;
  assign quot[0] = '0;

  // Restoring division, one quotient bit per stage. The first stage gives
  // the integer bit, so it compares the magnitude without doubling it.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [LW:0] cur;
    logic        take;

    if (j == 0) begin : g_first
      assign cur = {1'b0, rem[j]};
    end else begin : g_next
      assign cur = {rem[j], 1'b0};
    end

    assign take = cur >= {1'b0, dvs[j]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= take ? LW'(cur - {1'b0, dvs[j]}) : LW'(cur);
        dvs[j+1]  <= dvs[j];
        quot[j+1] <= {quot[j][QW-2:0], take};
      end
    end
  end

  assign quot_out = quot[DIV_STEPS];

endmodule

// ===== sv/vector4_normalize.sv =====
// Throughput: one request per cycle unless the output stalls; the 33-stage root
// pipeline and the four 31-stage divider lanes each take a new request every cycle.
// The whole pipeline holds while a result waits at the stalled output.
// Reset (rst, synchronous) clears every valid bit; data registers are not reset.
module vector4_normalize
  import vn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] comp_x,
  input  logic signed [CW-1:0] comp_y,
  input  logic signed [CW-1:0] comp_z,
  input  logic signed [CW-1:0] comp_w,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [UW-1:0] unit_x,
  output logic signed [UW-1:0] unit_y,
  output logic signed [UW-1:0] unit_z,
  output logic signed [UW-1:0] unit_w,
  output logic        [LW-1:0] length,
  output logic                 was_zero
);

`include "vector4_normalize_defines.svh"

  logic en;
  logic [LANES-1:0][CW-1:0] comp;

  // The pipeline advances unless a result is held at the output.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign comp     = {comp_w, comp_z, comp_y, comp_x};

  // Input stage: sign and magnitude of each component.
  logic                     a_valid;
  logic [LANES-1:0]         a_neg;
  logic [LANES-1:0][MW-1:0] a_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        a_neg[i] <= comp[i][CW-1];
        a_mag[i] <= comp[i][CW-1] ? MW'(-comp[i]) : MW'(comp[i]);
      end
    end
  end

  // Square stage: one multiplier per lane.
  logic                     b_valid;
  side_t                    b_side;
  logic [LANES-1:0][PW-1:0] b_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side.neg <= a_neg;
      b_side.mag <= a_mag;
      for (int i = 0; i < LANES; i++) begin
        b_sq[i] <= a_mag[i] * a_mag[i];
      end
    end
  end

  // Adder tree over two stages.
  logic          c_valid;
  side_t         c_side;
  logic [SW-1:0] c_sum0;
  logic [SW-1:0] c_sum1;
  logic          d_valid;
  side_t         d_side;
  logic [SW-1:0] d_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side <= b_side;
      c_sum0 <= SW'(b_sq[0]) + SW'(b_sq[1]);
      c_sum1 <= SW'(b_sq[2]) + SW'(b_sq[3]);
      d_side <= c_side;
      d_sum  <= c_sum0 + c_sum1;
    end
  end

  // Square root of the sum of squares.
  logic          r_valid;
  logic [LW-1:0] r_len;
  side_t         r_side;

  vn_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (d_valid),
    .sum_in    (d_sum),
    .side_in   (d_side),
    .valid_out (r_valid),
    .root_out  (r_len),
    .side_out  (r_side)
  );

  // Divider lanes, one per component.
  logic [LANES-1:0][QW-1:0] quot;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vn_div_lane u_div (
      .clk      (clk),
      .en       (en),
      .mag_in   (r_side.mag[i]),
      .len_in   (r_len),
      .quot_out (quot[i])
    );
  end

  // Request data that runs beside the divider lanes.
  tail_t tail [0:DIV_STEPS];

  assign tail[0] = '{valid: r_valid, zero: (r_len == '0), neg: r_side.neg, len: r_len};

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_tail
    always_ff @(posedge clk) begin
      if (rst) begin
        tail[j+1].valid <= 1'b0;
      end else if (en) begin
        tail[j+1].valid <= tail[j].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tail[j+1].zero <= tail[j].zero;
        tail[j+1].neg  <= tail[j].neg;
        tail[j+1].len  <= tail[j].len;
      end
    end
  end

  // Merge stage: apply signs, or give the unit x vector for a zero input.
  tail_t                    t_end;
  logic [LANES-1:0][UW-1:0] unit_next;

  assign t_end = tail[DIV_STEPS];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      unit_next[i] = t_end.neg[i] ? -UW'(quot[i]) : UW'(quot[i]);
    end
    if (t_end.zero) begin
      unit_next    = '0;
      unit_next[0] = UW'(1) << FB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= t_end.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_x   <= unit_next[0];
      unit_y   <= unit_next[1];
      unit_z   <= unit_next[2];
      unit_w   <= unit_next[3];
      length   <= t_end.len;
      was_zero <= t_end.zero;
    end
  end

  // A zero input gives a zero length and the unit x vector.
  `VN_ASSERT(a_zero_result, out_valid && was_zero |-> length == '0 && unit_x == (UW'(1) << FB) && unit_y == '0, "zero input result is wrong")
  // A nonzero input has a nonzero length.
  `VN_ASSERT(a_len_nonzero, out_valid && !was_zero |-> length != '0, "nonzero input with zero length")
  // The input side is held exactly while a result waits at the output.
  `VN_ASSERT_ALWAYS(a_stall_link, in_stall == (out_valid && out_stall), "input stall mismatch")
  // The x component does not exceed one in magnitude.
  `VN_ASSERT(a_unit_range, out_valid |-> unit_x <= $signed(UW'(1) << FB) && unit_x >= -$signed(UW'(1) << FB), "unit x out of range")

endmodule

// ===== verif/tb_vector4_normalize.sv =====
`timescale 1ns / 1ps

module tb_vector4_normalize;
  import vn_pkg::*;

  // One request to the normaliser and one expected result.
  typedef struct {
    logic signed [CW-1:0] x, y, z, w;
  } vec_t;

  typedef struct {
    logic signed [UW-1:0] ux, uy, uz, uw;
    logic [LW-1:0]        len;
    logic                 zero;
  } unit_t;

  localparam int LATENCY = 68;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] comp_x = '0, comp_y = '0, comp_z = '0, comp_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [UW-1:0] unit_x, unit_y, unit_z, unit_w;
  logic [LW-1:0] length;
  logic was_zero;

  vec_t  pending_vecs[$];
  unit_t expected_units[$];
  int    errors = 0;
  bit    stim_done = 1'b0;
  longint cycles = 0;

  vector4_normalize u_dut (.*);

  always #10 clk = ~clk;

  // Exact integer square root, truncated, of a sum of up to four squares.
  function automatic logic [LW-1:0] isqrt(logic [SW:0] s);
    logic [LW-1:0] r;
    logic [LW-1:0] c;
    r = '0;
    for (int b = LW - 1; b >= 0; b--) begin
      c = r | (LW'(1) << b);
      if ((SW+1)'(c) * (SW+1)'(c) <= s) r = c;
    end
    return r;
  endfunction

  // Normalised direction and length of one vector.
  function automatic unit_t normalise(vec_t v);
    unit_t u;
    logic signed [CW-1:0] c[LANES];
    logic [MW:0] m[LANES];
    logic [SW:0] s;
    logic [UW-1:0] q[LANES];
    logic [MW+FB:0] num;
    c[0] = v.x; c[1] = v.y; c[2] = v.z; c[3] = v.w;
    s = '0;
    for (int i = 0; i < LANES; i++) begin
      m[i] = c[i][CW-1] ? (MW+1)'(-(CW+1)'(c[i])) : (MW+1)'(c[i]);
      s += (SW+1)'(m[i]) * (SW+1)'(m[i]);
    end
    u.len = isqrt(s);
    u.zero = (u.len == 0);
    for (int i = 0; i < LANES; i++) begin
      if (u.zero) begin
        q[i] = (i == 0) ? (UW'(1) << FB) : '0;
      end else begin
        num = (MW+FB+1)'(m[i]) << FB;
        q[i] = UW'(num / (MW+FB+1)'(u.len));
        if (c[i][CW-1]) q[i] = -q[i];
      end
    end
    u.ux = q[0]; u.uy = q[1]; u.uz = q[2]; u.uw = q[3];
    if (u.zero) u.len = '0;
    return u;
  endfunction

  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(CW-1){1'b0}}};
      1: return {1'b0, {(CW-1){1'b1}}};
      2: return CW'($urandom_range(0, 3)) - 1;
      3: return CW'($signed($urandom_range(0, 8191)) - 4096);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic int gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 30);
  endfunction

  // Stimulus: directed corners then random vectors.
  initial begin
    logic [CW-1:0] mn, mx;
    vec_t v;
    mn = {1'b1, {(CW-1){1'b0}}};
    mx = {1'b0, {(CW-1){1'b1}}};
    pending_vecs.push_back('{0, 0, 0, 0});
    pending_vecs.push_back('{mn, mn, mn, mn});
    pending_vecs.push_back('{mx, mx, mx, mx});
    pending_vecs.push_back('{mn, 0, 0, 0});
    pending_vecs.push_back('{0, mn, 0, 0});
    pending_vecs.push_back('{0, 0, mx, 0});
    pending_vecs.push_back('{0, 0, 0, -1});
    pending_vecs.push_back('{1, 0, 0, 0});
    pending_vecs.push_back('{1, 1, 1, 1});
    pending_vecs.push_back('{-1, 1, -1, 1});
    pending_vecs.push_back('{mx, mn, mx, mn});
    pending_vecs.push_back('{3, -4, 0, 0});
    pending_vecs.push_back('{32'h0001_0000, 0, 0, 0});
    pending_vecs.push_back('{-32'sh0001_0000, 32'h0001_0000, 0, 0});
    pending_vecs.push_back('{32'hFFFFFFFF, 32'h0, 32'h7FFF, 32'h2});
    pending_vecs.push_back('{0, 0, 0, 0});
    repeat (850) begin
      v.x = rand_comp(); v.y = rand_comp(); v.z = rand_comp(); v.w = rand_comp();
      if ($urandom_range(0, 19) == 0) v = '{0, 0, 0, 0};
      pending_vecs.push_back(v);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: presents queued vectors, holding while stalled.
  int in_wait = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_units.push_back(normalise('{comp_x, comp_y, comp_z, comp_w}));
        in_wait = ($urandom_range(0, 2) == 0) ? gap() : 0;
      end else if (in_wait > 0) begin
        in_wait--;
      end
      if (!(in_valid && in_stall)) begin
        if (in_wait == 0 && pending_vecs.size() > 0) begin
          vec_t v;
          v = pending_vecs.pop_front();
          in_valid <= 1'b1;
          comp_x <= v.x; comp_y <= v.y; comp_z <= v.z; comp_w <= v.w;
        end else begin
          in_valid <= 1'b0;
          if (pending_vecs.size() == 0 && !(in_valid && !in_stall) && in_wait == 0)
            stim_done = 1'b1;
        end
      end
    end
  end

  // Monitor: compares each accepted result and applies random output stalls.
  int out_wait = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_units.size() == 0) begin
          $display("%0t: unexpected result len=%0d", $time, length);
          errors++;
        end else begin
          unit_t e;
          e = expected_units.pop_front();
          if ({unit_x, unit_y, unit_z, unit_w, length, was_zero} !==
              {e.ux, e.uy, e.uz, e.uw, e.len, e.zero}) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d len=%0d zero=%0b",
                     $time, e.ux, e.uy, e.uz, e.uw, e.len, e.zero);
            $display("%0t:            actual x=%0d y=%0d z=%0d w=%0d len=%0d zero=%0b",
                     $time, unit_x, unit_y, unit_z, unit_w, length, was_zero);
            errors++;
          end
        end
      end
      if (out_wait > 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        out_wait = gap();
        out_stall <= (out_wait > 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // End of run: drain, then allow the pipeline depth to pass.
  initial begin
    wait (stim_done);
    while (expected_units.size() > 0) @(posedge clk);
    repeat (LATENCY + 40) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
